// File: rtl/sfs_pkg.sv
package sfs_pkg;

  localparam int FRAME_W = 8;
  localparam int COUNT_W = 9;
  localparam int MODE_W  = 3;
  localparam int TIME_W  = 16;
  localparam int ACC_W   = 17;
  localparam int LOOP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST  = 9'd1;
  localparam logic [MODE_W-1:0]  PLAY_MODE_RST    = 3'd1;
  localparam logic [TIME_W-1:0]  FRAME_PERIOD_RST = 16'd1000;
  localparam logic [LOOP_W-1:0]  LOOP_TOTAL_RST   = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_TOTAL   = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_RESUME = 3'd3,
    OP_RESET  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_ONCE          = 3'd0,
    MODE_LOOP          = 3'd1,
    MODE_PINGPONG      = 3'd2,
    MODE_PINGPONG_ONCE = 3'd3,
    MODE_LOOP_N        = 3'd4,
    MODE_PINGPONG_N    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic add;
    logic step;
    logic restart;
    logic play;
    logic set_run;
    logic clr_run;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic can_step;
  } status_t;

endpackage

// File: rtl/sfs_ctrl.sv
module sfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0]       in_op_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  input  sfs_pkg::status_t status_i,
  output sfs_pkg::cmd_t    cmd_o
);

  sfs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sfs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sfs_pkg::op_e'(in_op_i) == sfs_pkg::OP_TICK) state_d = sfs_pkg::ST_RUN;
          else state_d = sfs_pkg::ST_DONE;
        end
      end
      sfs_pkg::ST_RUN: begin
        if (!status_i.can_step) state_d = sfs_pkg::ST_DONE;
      end
      sfs_pkg::ST_DONE: begin
        if (out_free) state_d = sfs_pkg::ST_IDLE;
      end
      default: state_d = sfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      sfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sfs_pkg::op_e'(in_op_i))
            sfs_pkg::OP_TICK:   cmd_o.add = status_i.running;
            sfs_pkg::OP_START: begin
              cmd_o.restart = 1'b1;
              cmd_o.play    = 1'b1;
            end
            sfs_pkg::OP_STOP:   cmd_o.clr_run = 1'b1;
            sfs_pkg::OP_RESUME: cmd_o.set_run = 1'b1;
            sfs_pkg::OP_RESET:  cmd_o.restart = 1'b1;
            default: ;
          endcase
        end
      end
      sfs_pkg::ST_RUN:  cmd_o.step = status_i.can_step;
      sfs_pkg::ST_DONE: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  // result register frees when its beat is taken
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/sfs_dpath.sv
module sfs_dpath #(
  parameter int FrameCap = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sfs_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [sfs_pkg::TIME_W-1:0]           in_elapsed_i,
  input  sfs_pkg::cmd_t                        cmd_i,
  output sfs_pkg::status_t                     status_o,
  output logic [sfs_pkg::FRAME_W-1:0]          out_frame_index_o,
  output logic                                 out_is_playing_o,
  output logic                                 out_going_back_o,
  output logic [sfs_pkg::LOOP_W-1:0]           out_loops_remaining_o
);

  localparam logic [sfs_pkg::COUNT_W-1:0] CapV = sfs_pkg::COUNT_W'(FrameCap);

  // configuration registers
  logic [sfs_pkg::COUNT_W-1:0] frame_count_q;
  logic [sfs_pkg::MODE_W-1:0]  play_mode_q;
  logic [sfs_pkg::TIME_W-1:0]  frame_period_q;
  logic [sfs_pkg::LOOP_W-1:0]  loop_total_q;

  // playback state
  logic [sfs_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [sfs_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic                        rev_q, rev_d;
  logic                        run_q, run_d;
  logic [sfs_pkg::LOOP_W-1:0]  loops_q, loops_d;

  // result register
  logic [sfs_pkg::FRAME_W-1:0] res_frame_q;
  logic                        res_run_q;
  logic                        res_rev_q;
  logic [sfs_pkg::LOOP_W-1:0]  res_loops_q;

  logic [sfs_pkg::TIME_W-1:0]  period;
  logic [sfs_pkg::ACC_W:0]     acc_sum;
  logic [sfs_pkg::COUNT_W-1:0] count_eff;
  logic [sfs_pkg::FRAME_W-1:0] last;
  logic [sfs_pkg::FRAME_W-1:0] f;

  logic [sfs_pkg::FRAME_W-1:0] pp_frame;
  logic                        pp_rev;
  logic                        pp_turn;
  logic [sfs_pkg::LOOP_W-1:0]  loops_dec;
  logic                        loops_end;

  logic [sfs_pkg::FRAME_W-1:0] adv_frame;
  logic                        adv_rev;
  logic                        adv_run;
  logic [sfs_pkg::LOOP_W-1:0]  adv_loops;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q  <= sfs_pkg::FRAME_COUNT_RST;
      play_mode_q    <= sfs_pkg::PLAY_MODE_RST;
      frame_period_q <= sfs_pkg::FRAME_PERIOD_RST;
      loop_total_q   <= sfs_pkg::LOOP_TOTAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfs_pkg::CFG_FRAME_COUNT:  frame_count_q  <= cfg_data_i[sfs_pkg::COUNT_W-1:0];
        sfs_pkg::CFG_PLAY_MODE:    play_mode_q    <= cfg_data_i[sfs_pkg::MODE_W-1:0];
        sfs_pkg::CFG_FRAME_PERIOD: frame_period_q <= cfg_data_i[sfs_pkg::TIME_W-1:0];
        sfs_pkg::CFG_LOOP_TOTAL:   loop_total_q   <= cfg_data_i[sfs_pkg::LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign period  = (frame_period_q == '0) ? sfs_pkg::TIME_W'(1) : frame_period_q;
  assign acc_sum = {1'b0, acc_q} + {2'b00, in_elapsed_i};

  assign status_o.running  = run_q;
  assign status_o.can_step = run_q && (acc_q >= {1'b0, period});

  // frame count clamped to 1..cap, last frame index and clamped current frame
  assign count_eff = (frame_count_q == '0) ? sfs_pkg::COUNT_W'(1) :
                     (frame_count_q > CapV) ? CapV : frame_count_q;
  assign last = sfs_pkg::FRAME_W'(count_eff - sfs_pkg::COUNT_W'(1));
  assign f    = (frame_q > last) ? last : frame_q;

  // ping-pong turning step
  always_comb begin
    pp_frame = f;
    pp_rev   = rev_q;
    pp_turn  = 1'b0;
    if (!rev_q && (f < last)) begin
      pp_frame = f + 8'd1;
    end else if (rev_q && (f != '0)) begin
      pp_frame = f - 8'd1;
    end else begin
      pp_rev  = !rev_q;
      pp_turn = rev_q;
      if (last != '0) begin
        pp_frame = rev_q ? (f + 8'd1) : (f - 8'd1);
      end
    end
  end

  assign loops_dec = (loops_q != '0) ? (loops_q - 16'd1) : loops_q;
  assign loops_end = (loops_dec == '0);

  always_comb begin
    adv_frame = f;
    adv_rev   = rev_q;
    adv_run   = run_q;
    adv_loops = loops_q;
    case (sfs_pkg::mode_e'(play_mode_q))
      sfs_pkg::MODE_ONCE: begin
        if (f < last) adv_frame = f + 8'd1;
        else adv_run = 1'b0;
      end
      sfs_pkg::MODE_LOOP: begin
        adv_frame = (f < last) ? (f + 8'd1) : '0;
      end
      sfs_pkg::MODE_PINGPONG: begin
        adv_frame = pp_frame;
        adv_rev   = pp_rev;
      end
      sfs_pkg::MODE_PINGPONG_ONCE: begin
        if (!rev_q) begin
          if (f < last) begin
            adv_frame = f + 8'd1;
          end else begin
            adv_rev = 1'b1;
            if (f != '0) adv_frame = f - 8'd1;
          end
        end else begin
          if (f != '0) adv_frame = f - 8'd1;
          else adv_run = 1'b0;
        end
      end
      sfs_pkg::MODE_LOOP_N: begin
        if (f < last) begin
          adv_frame = f + 8'd1;
        end else begin
          adv_frame = '0;
          adv_loops = loops_dec;
          if (loops_end) adv_run = 1'b0;
        end
      end
      sfs_pkg::MODE_PINGPONG_N: begin
        adv_frame = pp_frame;
        adv_rev   = pp_rev;
        if (pp_turn) begin
          adv_loops = loops_dec;
          if (loops_end) begin
            adv_run   = 1'b0;
            adv_frame = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    frame_d = frame_q;
    rev_d   = rev_q;
    run_d   = run_q;
    loops_d = loops_q;
    if (cmd_i.add) begin
      acc_d = acc_sum[sfs_pkg::ACC_W] ? sfs_pkg::ACC_MAX : acc_sum[sfs_pkg::ACC_W-1:0];
    end
    if (cmd_i.step) begin
      acc_d   = acc_q - {1'b0, period};
      frame_d = adv_frame;
      rev_d   = adv_rev;
      run_d   = adv_run;
      loops_d = adv_loops;
    end
    if (cmd_i.restart) begin
      acc_d   = '0;
      frame_d = '0;
      rev_d   = 1'b0;
      run_d   = cmd_i.play;
      loops_d = loop_total_q;
    end
    if (cmd_i.set_run) run_d = 1'b1;
    if (cmd_i.clr_run) run_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      frame_q <= '0;
      rev_q   <= 1'b0;
      run_q   <= 1'b1;
      loops_q <= '0;
    end else begin
      acc_q   <= acc_d;
      frame_q <= frame_d;
      rev_q   <= rev_d;
      run_q   <= run_d;
      loops_q <= loops_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_frame_q <= frame_q;
      res_run_q   <= run_q;
      res_rev_q   <= rev_q;
      res_loops_q <= loops_q;
    end
  end

  assign out_frame_index_o     = res_frame_q;
  assign out_is_playing_o      = res_run_q;
  assign out_going_back_o      = res_rev_q;
  assign out_loops_remaining_o = res_loops_q;

endmodule

// File: rtl/sprite_frame_sequencer.sv
// sequence: a command beat goes from IDLE to DONE; a tick beat advancing the frame n times
//   first steps in RUN, one advance per cycle, then goes to DONE
// intake: the next beat is taken only back in IDLE, after DONE has loaded the result once the
//   output is free; the frame advance unit does one period subtraction per cycle
// reset: playing set, frame 0, forward, accumulator and loop count zero, registers at
//   their defaults; no result pending
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sfs_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           in_op_i,
  input  logic [sfs_pkg::TIME_W-1:0]           in_elapsed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sfs_pkg::FRAME_W-1:0]          out_frame_index_o,
  output logic                                 out_is_playing_o,
  output logic                                 out_going_back_o,
  output logic [sfs_pkg::LOOP_W-1:0]           out_loops_remaining_o
);

  localparam int FrameCap = (MAX_FRAMES > 256) ? 256 : MAX_FRAMES;

  sfs_pkg::cmd_t    cmd;
  sfs_pkg::status_t status;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_op_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfs_dpath #(
    .FrameCap (FrameCap)
  ) u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_elapsed_i          (in_elapsed_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .out_frame_index_o     (out_frame_index_o),
    .out_is_playing_o      (out_is_playing_o),
    .out_going_back_o      (out_going_back_o),
    .out_loops_remaining_o (out_loops_remaining_o)
  );

  // an advance only happens with a full period in the accumulator
  a_step_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> status.can_step)
    else $error("frame advance without a full period");

  // one beat in flight: input closes right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat accepted while busy");

  // loading the result always presents a beat
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result loaded but not presented");

  // datapath commands never collide
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.add, cmd.step, cmd.restart, cmd.set_run, cmd.clr_run, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule
